@@ rtl/core/bit_field_packer_unpacker_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Bit field packer/unpacker assertion macros
// Shared forms for the concurrent checks of the bit stream unit.
// ----------------------------------------------------------------------------
`ifndef BIT_FIELD_PACKER_UNPACKER_UNIT_ASSERT_SVH
`define BIT_FIELD_PACKER_UNPACKER_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define BFPU_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("bit field packer unpacker: check failed");

// A consequent that must hold in the cycle after its antecedent.
`define BFPU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bit field packer unpacker: next-cycle check failed");

`endif

@@ rtl/core/bfpu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit field packer/unpacker package
// Sizes, request and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bfpu_pkg;

    // Store geometry and field widths.
    localparam int STORE_BYTES   = 512;
    localparam int MAX_BITS      = 32;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int CAPACITY_BITS = STORE_BYTES * 8;
    localparam int POS_W         = 13;
    localparam int COUNT_W       = 6;
    localparam int VALUE_W       = 32;

    // Worst-case number of bytes one access touches, and its bit span.
    localparam int SPAN_BYTES = (MAX_BITS + 14) / 8;
    localparam int SPAN_W     = SPAN_BYTES * 8;
    localparam int IDX_W      = $clog2(SPAN_BYTES + 1);

    // Request codes.
    localparam logic [1:0] REQ_WRITE    = 2'd0;
    localparam logic [1:0] REQ_READ     = 2'd1;
    localparam logic [1:0] REQ_SET_WPOS = 2'd2;
    localparam logic [1:0] REQ_SET_RPOS = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_READ_PAST = 2'd1;
    localparam logic [1:0] ST_CAPACITY  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic check;
        logic xfer;
        logic finish;
    } bfpu_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic need_xfer;
        logic xfer_last;
        logic out_free;
    } bfpu_stat_t;

endpackage

@@ rtl/core/bit_field_packer_unpacker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit field packer/unpacker unit
// LSB-first bit stream writer and reader over a 512-byte store.
// ----------------------------------------------------------------------------
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   req_type, bit_count, write_value, new_position
//   out      out_valid / out_ready read_value, status, write_position, read_position
//
// A write or read touches n bytes (1 to 5). The byte store's single read and
// single write port allow one byte read-modify-write per cycle, overlapped
// one deep. Position loads, failed checks and zero counts move no bytes.
// After reset a clearing pass zeroes the store; in_ready stays low meanwhile.
// A stalled result holds in the output register; the next request is still
// taken, and its result waits until the output register is free.
// ----------------------------------------------------------------------------
module bit_field_packer_unpacker_unit
    import bfpu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [COUNT_W-1:0] bit_count,
    input  logic [VALUE_W-1:0] write_value,
    input  logic [POS_W-1:0]   new_position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] read_value,
    output logic [1:0]         status,
    output logic [POS_W-1:0]   write_position,
    output logic [POS_W-1:0]   read_position
);

    bfpu_cmd_t  cmd;
    bfpu_stat_t stat;

    // Sequencer.
    bfpu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Store, positions and result register.
    bfpu_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_type       (req_type),
        .bit_count      (bit_count),
        .write_value    (write_value),
        .new_position   (new_position),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .read_value     (read_value),
        .status         (status),
        .write_position (write_position),
        .read_position  (read_position)
    );

endmodule

@@ rtl/core/bfpu_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit field packer/unpacker controller
// Sequences the clearing pass, request capture, check, byte transfer and
// result hand-off.
// ----------------------------------------------------------------------------
module bfpu_ctrl
    import bfpu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  bfpu_stat_t stat,
    output bfpu_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_CHECK  = 5'b00100,
        S_XFER   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the clearing pass over the store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.need_xfer ? S_XFER : S_FINISH;
            end
            S_XFER:
            begin
                cmd.xfer = 1'b1;
                if (stat.xfer_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

@@ rtl/core/bfpu_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit field packer/unpacker datapath
// Byte store, bit positions, range checks, byte-wise read-modify-write and
// gather, and the result register.
// ----------------------------------------------------------------------------
module bfpu_dpath
    import bfpu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  bfpu_cmd_t          cmd,
    output bfpu_stat_t         stat,
    input  logic [1:0]         req_type,
    input  logic [COUNT_W-1:0] bit_count,
    input  logic [VALUE_W-1:0] write_value,
    input  logic [POS_W-1:0]   new_position,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [VALUE_W-1:0] read_value,
    output logic [1:0]         status,
    output logic [POS_W-1:0]   write_position,
    output logic [POS_W-1:0]   read_position
);

    // Byte store and its registered read data.
    logic [7:0]          mem [STORE_BYTES];
    logic [7:0]          mem_rdata_reg;

    // Captured request.
    logic [1:0]          req_reg;
    logic [COUNT_W-1:0]  cnt_reg;
    logic [VALUE_W-1:0]  val_reg;
    logic [POS_W-1:0]    npos_reg;

    // Stream positions.
    logic [POS_W-1:0]    wpos_reg;
    logic [POS_W-1:0]    rpos_reg;
    logic [POS_W-1:0]    wpos_next;
    logic [POS_W-1:0]    rpos_next;

    // Results of the check step.
    logic [1:0]          status_reg;
    logic [2:0]          off_reg;
    logic [ADDR_W-1:0]   first_reg;
    logic [IDX_W-1:0]    nbytes_reg;
    logic [SPAN_W-1:0]   data_reg;
    logic [SPAN_W-1:0]   mask_reg;

    // Transfer progress.
    logic [IDX_W-1:0]    rd_k_reg;
    logic [IDX_W-1:0]    wb_k_reg;
    logic                rd_pend_reg;
    logic [SPAN_W-1:0]   acc_reg;
    logic [ADDR_W-1:0]   clr_idx_reg;

    // Result register.
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  rv_reg;
    logic [1:0]          ost_reg;
    logic [POS_W-1:0]    owpos_reg;
    logic [POS_W-1:0]    orpos_reg;

    // Combinational terms.
    logic [COUNT_W-1:0]  cnt_clamped;
    logic [POS_W:0]      wsum;
    logic [POS_W:0]      rsum;
    logic [POS_W-1:0]    base_pos;
    logic [1:0]          chk_status;
    logic                need_xfer;
    logic [6:0]          span_sum;
    logic [SPAN_W-1:0]   chk_data;
    logic [SPAN_W-1:0]   chk_mask;
    logic                rd_issue;
    logic                wb_fire;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wb_addr;
    logic [7:0]          sel_data;
    logic [7:0]          sel_mask;
    logic [7:0]          merged;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;
    logic [SPAN_W-1:0]   acc_shift;
    logic [SPAN_W-1:0]   mask_shift;
    logic [VALUE_W-1:0]  rv_next;

    // Counts above the widest field saturate.
    assign cnt_clamped = (bit_count > COUNT_W'(MAX_BITS)) ? COUNT_W'(MAX_BITS) : bit_count;

    // Capture of an accepted request.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req_type;
            cnt_reg  <= cnt_clamped;
            val_reg  <= write_value;
            npos_reg <= new_position;
        end
    end

    // Range checks and the byte span of the access.
    always_comb
    begin
        wsum     = {1'b0, wpos_reg} + (POS_W + 1)'(cnt_reg);
        rsum     = {1'b0, rpos_reg} + (POS_W + 1)'(cnt_reg);
        base_pos = (req_reg == REQ_READ) ? rpos_reg : wpos_reg;
        unique case (req_reg)
            REQ_WRITE:
            begin
                chk_status = (wsum > (POS_W + 1)'(CAPACITY_BITS)) ? ST_CAPACITY : ST_OK;
            end
            REQ_READ:
            begin
                chk_status = (rsum > {1'b0, wpos_reg}) ? ST_READ_PAST : ST_OK;
            end
            default:
            begin
                chk_status = (npos_reg > POS_W'(CAPACITY_BITS)) ? ST_CAPACITY : ST_OK;
            end
        endcase
        need_xfer = ((req_reg == REQ_WRITE) || (req_reg == REQ_READ))
                    && (chk_status == ST_OK) && (cnt_reg != '0);
        span_sum  = {4'b0000, base_pos[2:0]} + {1'b0, cnt_reg} + 7'd7;
        chk_data  = SPAN_W'(val_reg) << base_pos[2:0];
        chk_mask  = ((SPAN_W'(1) << cnt_reg) - SPAN_W'(1)) << base_pos[2:0];
    end

    // Check-step registers.
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            status_reg <= chk_status;
            off_reg    <= base_pos[2:0];
            first_reg  <= base_pos[ADDR_W+2:3];
            nbytes_reg <= IDX_W'(span_sum >> 3);
            data_reg   <= chk_data;
            mask_reg   <= chk_mask;
        end
    end

    // Byte transfer: a read is issued each cycle while the byte of the
    // previous cycle is merged back or gathered.
    always_comb
    begin
        rd_issue  = cmd.xfer && (rd_k_reg < nbytes_reg);
        wb_fire   = cmd.xfer && rd_pend_reg;
        rd_addr   = first_reg + ADDR_W'(rd_k_reg);
        wb_addr   = first_reg + ADDR_W'(wb_k_reg);
        sel_data  = data_reg[{wb_k_reg, 3'b000} +: 8];
        sel_mask  = mask_reg[{wb_k_reg, 3'b000} +: 8];
        merged    = (mem_rdata_reg & ~sel_mask) | (sel_data & sel_mask);
        mem_we    = 1'b0;
        mem_waddr = wb_addr;
        mem_wdata = merged;
        if (cmd.clear)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else if (wb_fire && (req_reg == REQ_WRITE))
        begin
            mem_we = 1'b1;
        end
    end

    // Store write port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Store read port.
    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            mem_rdata_reg <= mem[rd_addr];
        end
    end

    // Transfer counters and the gather register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_k_reg    <= '0;
            wb_k_reg    <= '0;
            rd_pend_reg <= 1'b0;
        end
        else if (cmd.check)
        begin
            rd_k_reg    <= '0;
            rd_pend_reg <= 1'b0;
        end
        else if (cmd.xfer)
        begin
            rd_pend_reg <= rd_issue;
            if (rd_issue)
            begin
                wb_k_reg <= rd_k_reg;
                rd_k_reg <= IDX_W'(rd_k_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            acc_reg <= '0;
        end
        else if (wb_fire && (req_reg == REQ_READ))
        begin
            acc_reg[{wb_k_reg, 3'b000} +: 8] <= mem_rdata_reg;
        end
    end

    // Clearing pass address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_idx_reg <= ADDR_W'(clr_idx_reg + 1'b1);
        end
    end

    // Position update and the value read.
    always_comb
    begin
        wpos_next = wpos_reg;
        rpos_next = rpos_reg;
        if (status_reg == ST_OK)
        begin
            unique case (req_reg)
                REQ_WRITE:    wpos_next = wpos_reg + POS_W'(cnt_reg);
                REQ_READ:     rpos_next = rpos_reg + POS_W'(cnt_reg);
                REQ_SET_WPOS: wpos_next = npos_reg;
                REQ_SET_RPOS: rpos_next = npos_reg;
                default:      wpos_next = wpos_reg;
            endcase
        end
        acc_shift  = acc_reg >> off_reg;
        mask_shift = mask_reg >> off_reg;
        rv_next    = ((req_reg == REQ_READ) && (status_reg == ST_OK))
                     ? (acc_shift[VALUE_W-1:0] & mask_shift[VALUE_W-1:0]) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg <= '0;
            rpos_reg <= '0;
        end
        else if (cmd.finish)
        begin
            wpos_reg <= wpos_next;
            rpos_reg <= rpos_next;
        end
    end

    // Result register; it holds while the downstream side stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rv_reg    <= rv_next;
            ost_reg   <= status_reg;
            owpos_reg <= wpos_next;
            orpos_reg <= rpos_next;
        end
    end

    // Status toward the controller.
    assign stat.clear_last = (clr_idx_reg == ADDR_W'(STORE_BYTES - 1));
    assign stat.need_xfer  = need_xfer;
    assign stat.xfer_last  = rd_pend_reg && (rd_k_reg == nbytes_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign read_value     = rv_reg;
    assign status         = ost_reg;
    assign write_position = owpos_reg;
    assign read_position  = orpos_reg;

endmodule

@@ rtl/core/bfpu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit field packer/unpacker port checker
// Concurrent checks on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
`include "bit_field_packer_unpacker_unit_assert.svh"

module bfpu_checker
    import bfpu_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         req_type,
    input logic [COUNT_W-1:0] bit_count,
    input logic [VALUE_W-1:0] write_value,
    input logic [POS_W-1:0]   new_position,
    input logic               out_valid,
    input logic               out_ready,
    input logic [VALUE_W-1:0] read_value,
    input logic [1:0]         status,
    input logic [POS_W-1:0]   write_position,
    input logic [POS_W-1:0]   read_position
);

    logic [VALUE_W+2*POS_W+1:0] out_bus;
    logic                       pos_ok;

    // The whole result payload, watched as one word.
    assign out_bus = {read_value, status, write_position, read_position};

    // Positions stay within the store and the status is a known code.
    assign pos_ok = (write_position <= POS_W'(CAPACITY_BITS))
                    && (read_position <= POS_W'(CAPACITY_BITS))
                    && (status <= ST_CAPACITY);

    // A stalled result keeps its valid and payload.
    `BFPU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bus))

    // Requests are worked one at a time: ready drops right after acceptance.
    `BFPU_ASSERT_NEXT(a_one_request, clk, rst_n, in_valid && in_ready, !in_ready)

    // A request that fails its check returns no data.
    `BFPU_ASSERT(a_zero_on_error, clk, rst_n, (out_valid && (status != ST_OK)) |-> (read_value == '0))

    // Positions never pass the store capacity and status is a known code.
    `BFPU_ASSERT(a_pos_in_range, clk, rst_n, out_valid |-> pos_ok)

endmodule

bind bit_field_packer_unpacker_unit bfpu_checker u_bfpu_checker (.*);
